// ----- rtl/h264_rtp_fua_packetizer_defines.svh -----
// Assertion macros used by the checker file.
`ifndef H264_RTP_FUA_PACKETIZER_DEFINES_SVH
`define H264_RTP_FUA_PACKETIZER_DEFINES_SVH

// Implication checked in the same cycle, ignored while reset is applied.
`define RFP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("packetizer check failed");

// Implication checked in the next cycle, ignored while reset is applied.
`define RFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("packetizer check failed");

// Implication checked in the next cycle, active during reset as well.
`define RFP_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("packetizer reset check failed");

`endif

// ----- rtl/h264rtp_pkg.sv -----
package h264rtp_pkg;

    localparam int unsigned PT_W    = 7;
    localparam int unsigned SSRC_W  = 32;
    localparam int unsigned STEP_W  = 17;
    localparam int unsigned MP_W    = 13;
    localparam int unsigned SEQ_W   = 16;
    localparam int unsigned TS_W    = 32;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [PT_W-1:0]   PT_RESET   = PT_W'(96);
    localparam logic [SSRC_W-1:0] SSRC_RESET = 32'h9876_5432;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(90000 / 24);
    localparam logic [MP_W-1:0]   MP_RESET   = MP_W'(1400);
    localparam logic [MP_W-1:0]   MP_MIN     = MP_W'(2);
    localparam logic [MP_W-1:0]   MP_MAX     = MP_W'(4096);

    localparam logic [7:0] RTP_V2_BYTE  = 8'h80;
    localparam logic [7:0] FU_INDICATOR = 8'h7C;
    localparam logic [7:0] FU_START     = 8'h80;
    localparam logic [7:0] FU_END       = 8'h40;

    // Result positions inside a run
    localparam logic [IDX_W-1:0] IDX_AFTER_HDR = IDX_W'(12);
    localparam logic [IDX_W-1:0] IDX_FU_HDR    = IDX_W'(13);
    localparam logic [IDX_W-1:0] IDX_FRAG_DATA = IDX_W'(14);

    typedef enum logic [1:0] {
        CFG_PAYLOAD_TYPE = 2'd0,
        CFG_SSRC         = 2'd1,
        CFG_TS_STEP      = 2'd2,
        CFG_MAX_PAYLOAD  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PT_W-1:0]   payload_type;
        logic [SSRC_W-1:0] ssrc;
        logic [STEP_W-1:0] ts_step;
        logic [MP_W-1:0]   max_payload;
    } t_cfg;

    // What one input byte produces
    typedef enum logic [1:0] {
        RUN_BODY   = 2'd0,  // data byte only
        RUN_SINGLE = 2'd1,  // RTP header, then data byte
        RUN_FRAG   = 2'd2   // RTP header, FU indicator, FU header, data byte
    } t_run_kind;

    typedef struct packed {
        t_run_kind        kind;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
        logic [7:0]       fu_hdr;
        logic [7:0]       data;
        logic             eop;
    } t_run;

endpackage

// ----- rtl/h264rtp_cfg.sv -----
module h264rtp_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [1:0]                          i_cfg_index,
    input  logic [h264rtp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                o_cfg_ready,
    output h264rtp_pkg::t_cfg                   o_cfg
);

    h264rtp_pkg::t_cfg r_cfg;
    h264rtp_pkg::t_cfg n_cfg;
    h264rtp_pkg::t_cfg_idx idx;

    assign o_cfg_ready = 1'b1;
    assign idx         = h264rtp_pkg::t_cfg_idx'(i_cfg_index);
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (idx)
                h264rtp_pkg::CFG_PAYLOAD_TYPE:
                    n_cfg.payload_type = i_cfg_data[h264rtp_pkg::PT_W-1:0];
                h264rtp_pkg::CFG_SSRC:
                    n_cfg.ssrc = i_cfg_data[h264rtp_pkg::SSRC_W-1:0];
                h264rtp_pkg::CFG_TS_STEP:
                    n_cfg.ts_step = i_cfg_data[h264rtp_pkg::STEP_W-1:0];
                h264rtp_pkg::CFG_MAX_PAYLOAD:
                    n_cfg.max_payload = i_cfg_data[h264rtp_pkg::MP_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.payload_type <= h264rtp_pkg::PT_RESET;
            r_cfg.ssrc         <= h264rtp_pkg::SSRC_RESET;
            r_cfg.ts_step      <= h264rtp_pkg::STEP_RESET;
            r_cfg.max_payload  <= h264rtp_pkg::MP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/h264rtp_parse.sv -----
module h264rtp_parse (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  h264rtp_pkg::t_cfg                  i_cfg,
    input  logic                               i_in_valid,
    input  logic [7:0]                         i_data_byte,
    input  logic [h264rtp_pkg::LEN_W-1:0]      i_nal_length,
    output logic                               o_in_stall,
    input  logic                               i_run_take,
    output logic                               o_run_valid,
    output h264rtp_pkg::t_run                  o_run
);

    localparam int unsigned LW = h264rtp_pkg::LEN_W;
    localparam int unsigned MW = h264rtp_pkg::MP_W;

    logic [h264rtp_pkg::SEQ_W-1:0] r_seq, n_seq;
    logic [h264rtp_pkg::TS_W-1:0]  r_ts, n_ts;
    logic [LW-1:0]                 r_pos, n_pos;
    logic [MW-1:0]                 r_fill, n_fill;
    logic [LW-1:0]                 r_len, n_len;
    logic                          r_frag, n_frag;
    logic [4:0]                    r_type, n_type;
    logic                          r_run_valid, n_run_valid;
    h264rtp_pkg::t_run             r_run, n_run;

    logic          accept;
    logic          has_run;
    logic [MW-1:0] mp;
    logic [LW-1:0] len_l;
    logic          last_body;
    logic [MW-1:0] fill;
    logic          end_frag;
    logic [LW-1:0] remain;

    assign o_in_stall  = r_run_valid && !i_run_take;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_run_valid = r_run_valid;
    assign o_run       = r_run;

    always_comb begin
        if (i_cfg.max_payload < h264rtp_pkg::MP_MIN) begin
            mp = h264rtp_pkg::MP_MIN;
        end else if (i_cfg.max_payload > h264rtp_pkg::MP_MAX) begin
            mp = h264rtp_pkg::MP_MAX;
        end else begin
            mp = i_cfg.max_payload;
        end
    end

    assign len_l     = (i_nal_length == '0) ? LW'(1) : i_nal_length;
    assign last_body = ({1'b0, r_pos} + (LW+1)'(1)) >= {1'b0, r_len};
    assign fill      = r_fill + MW'(1);
    assign end_frag  = last_body || (fill >= mp);
    assign remain    = r_len - r_pos;

    always_comb begin
        n_seq       = r_seq;
        n_ts        = r_ts;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_len       = r_len;
        n_frag      = r_frag;
        n_type      = r_type;
        has_run     = 1'b0;
        n_run       = r_run;

        if (accept) begin
            n_run.seq    = r_seq;
            n_run.ts     = r_ts;
            n_run.data   = i_data_byte;
            n_run.fu_hdr = {3'b000, r_type};
            n_run.eop    = 1'b0;
            n_run.kind   = h264rtp_pkg::RUN_BODY;
            if (r_pos == '0) begin
                n_len  = len_l;
                n_type = i_data_byte[4:0];
                n_frag = len_l > LW'(mp);
                n_fill = '0;
                if (len_l > LW'(mp)) begin
                    // header byte is absorbed into the FU header
                    n_pos = LW'(1);
                end else begin
                    has_run    = 1'b1;
                    n_run.kind = h264rtp_pkg::RUN_SINGLE;
                    n_run.eop  = (len_l == LW'(1));
                    if (len_l == LW'(1)) begin
                        n_seq = r_seq + 1'b1;
                        n_ts  = r_ts + h264rtp_pkg::TS_W'(i_cfg.ts_step);
                        n_pos = '0;
                    end else begin
                        n_pos = LW'(1);
                    end
                end
            end else if (!r_frag) begin
                has_run   = 1'b1;
                n_run.eop = last_body;
                if (last_body) begin
                    n_seq  = r_seq + 1'b1;
                    n_ts   = r_ts + h264rtp_pkg::TS_W'(i_cfg.ts_step);
                    n_pos  = '0;
                    n_fill = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end else begin
                has_run   = 1'b1;
                n_run.eop = end_frag;
                if (r_fill == '0) begin
                    n_run.kind = h264rtp_pkg::RUN_FRAG;
                    if (r_pos == LW'(1)) begin
                        n_run.fu_hdr = n_run.fu_hdr | h264rtp_pkg::FU_START;
                    end
                    if (remain <= LW'(mp)) begin
                        n_run.fu_hdr = n_run.fu_hdr | h264rtp_pkg::FU_END;
                    end
                end
                if (end_frag) begin
                    n_seq  = r_seq + 1'b1;
                    n_fill = '0;
                end else begin
                    n_fill = fill;
                end
                if (last_body) begin
                    n_ts   = r_ts + h264rtp_pkg::TS_W'(i_cfg.ts_step);
                    n_pos  = '0;
                    n_fill = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end

        if (accept && has_run) begin
            n_run_valid = 1'b1;
        end else if (i_run_take) begin
            n_run_valid = 1'b0;
        end else begin
            n_run_valid = r_run_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= '0;
            r_ts        <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_len       <= '0;
            r_frag      <= 1'b0;
            r_type      <= '0;
            r_run_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_ts        <= n_ts;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_len       <= n_len;
            r_frag      <= n_frag;
            r_type      <= n_type;
            r_run_valid <= n_run_valid;
        end
    end

    // descriptor payload: no reset
    always_ff @(posedge i_clk) begin
        if (accept && has_run) begin
            r_run <= n_run;
        end
    end

endmodule

// ----- rtl/h264rtp_emit.sv -----
module h264rtp_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  h264rtp_pkg::t_cfg     i_cfg,
    input  logic                  i_run_valid,
    input  h264rtp_pkg::t_run     i_run,
    output logic                  o_run_take,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_end_of_packet,
    output logic                  o_last_of_run
);

    localparam int unsigned IW = h264rtp_pkg::IDX_W;

    logic [IW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_byte, n_byte;
    logic          r_eop, n_eop;
    logic          r_last, n_last;

    logic          out_free;
    logic          load;
    logic [IW-1:0] last_idx;
    logic          at_last;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign load       = i_run_valid && out_free;

    always_comb begin
        case (i_run.kind)
            h264rtp_pkg::RUN_SINGLE: last_idx = h264rtp_pkg::IDX_AFTER_HDR;
            h264rtp_pkg::RUN_FRAG:   last_idx = h264rtp_pkg::IDX_FRAG_DATA;
            default:                 last_idx = '0;
        endcase
    end

    assign at_last    = (r_idx == last_idx);
    assign o_run_take = load && at_last;

    always_comb begin
        case (r_idx)
            IW'(0):  n_byte = h264rtp_pkg::RTP_V2_BYTE;
            IW'(1):  n_byte = {1'b0, i_cfg.payload_type};
            IW'(2):  n_byte = i_run.seq[15:8];
            IW'(3):  n_byte = i_run.seq[7:0];
            IW'(4):  n_byte = i_run.ts[31:24];
            IW'(5):  n_byte = i_run.ts[23:16];
            IW'(6):  n_byte = i_run.ts[15:8];
            IW'(7):  n_byte = i_run.ts[7:0];
            IW'(8):  n_byte = i_cfg.ssrc[31:24];
            IW'(9):  n_byte = i_cfg.ssrc[23:16];
            IW'(10): n_byte = i_cfg.ssrc[15:8];
            IW'(11): n_byte = i_cfg.ssrc[7:0];
            h264rtp_pkg::IDX_AFTER_HDR:
                n_byte = (i_run.kind == h264rtp_pkg::RUN_FRAG) ?
                         h264rtp_pkg::FU_INDICATOR : i_run.data;
            h264rtp_pkg::IDX_FU_HDR: n_byte = i_run.fu_hdr;
            default: n_byte = i_run.data;
        endcase
        // a body run carries the data byte alone
        if (i_run.kind == h264rtp_pkg::RUN_BODY) begin
            n_byte = i_run.data;
        end
        // the data byte always closes the run
        n_eop  = at_last && i_run.eop;
        n_last = at_last;

        if (load) begin
            n_idx = at_last ? '0 : r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end

        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_eop  <= n_eop;
            r_last <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_byte;
    assign o_end_of_packet = r_eop;
    assign o_last_of_run   = r_last;

endmodule

// ----- rtl/h264_rtp_fua_packetizer.sv -----
// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_stall     i_data_byte, i_nal_length
// out       source     o_out_valid / i_out_stall   o_out_byte, o_end_of_packet, o_last_of_run
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Body bytes pass at one byte per cycle while the output is not stalled. The first byte
// of a packet expands into a 13-byte run (12-byte RTP header plus data) or a 15-byte
// run for an FU-A fragment (header, indicator, FU header, data), set by the output byte
// serializer; the NAL header byte of a fragmented unit is absorbed and emits nothing.
// Reset is synchronous, active low; control and config registers return to their
// defaults and an item can be taken the cycle after reset. o_in_stall rises only while
// a pending run cannot move on; a stalled output holds its byte.
module h264_rtp_fua_packetizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_data_byte,
    input  logic [h264rtp_pkg::LEN_W-1:0]      i_nal_length,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [7:0]                         o_out_byte,
    output logic                               o_end_of_packet,
    output logic                               o_last_of_run,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [h264rtp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    h264rtp_pkg::t_cfg cfg;
    h264rtp_pkg::t_run run;
    logic              run_valid;
    logic              run_take;

    h264rtp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    h264rtp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_nal_length (i_nal_length),
        .o_in_stall   (o_in_stall),
        .i_run_take   (run_take),
        .o_run_valid  (run_valid),
        .o_run        (run)
    );

    h264rtp_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_run_valid     (run_valid),
        .i_run           (run),
        .o_run_take      (run_take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_end_of_packet (o_end_of_packet),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

// ----- rtl/h264rtp_check.sv -----
`include "h264_rtp_fua_packetizer_defines.svh"

module h264rtp_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_in_stall,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic [7:0]                         o_out_byte,
    input  logic                               o_end_of_packet,
    input  logic                               o_last_of_run
);

    logic [9:0] out_word;

    assign out_word = {o_out_byte, o_end_of_packet, o_last_of_run};

    // a stalled transaction keeps its byte and flags
    `RFP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_word))

    // a packet always ends on the data byte that closes a run
    `RFP_ASSERT_SAME(a_eop_closes_run, o_out_valid && o_end_of_packet, o_last_of_run)

    // reset empties the output and the pending run
    `RFP_ASSERT_RST(a_rst_out_idle, !i_rst_n, !o_out_valid && !o_in_stall)

    // with the output free and nothing shown, the input is never blocked for long:
    // a stall while the output sits empty is always followed by a shown byte
    `RFP_ASSERT_NEXT(a_stall_needs_run, !o_out_valid && o_in_stall, o_out_valid)

endmodule

bind h264_rtp_fua_packetizer h264rtp_check u_check (.*);

// ----- bench/h264_rtp_fua_packetizer_checker.sv -----
`timescale 1ns / 1ps

module h264_rtp_fua_packetizer_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [7:0]                         i_data_byte,
    input  logic [h264rtp_pkg::LEN_W-1:0]      i_nal_length,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [7:0]                         i_out_byte,
    input  logic                               i_end_of_packet,
    input  logic                               i_last_of_run,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [h264rtp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import h264rtp_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       eop;
        logic       last;
    } t_rtp_byte;

    t_rtp_byte rtp_bytes_due[$];

    logic [PT_W-1:0]   pt_reg;
    logic [SSRC_W-1:0] ssrc_reg;
    logic [STEP_W-1:0] ts_step_reg;
    logic [MP_W-1:0]   mp_reg;

    logic [SEQ_W-1:0]  next_seq;
    logic [TS_W-1:0]   rtp_time;
    logic [LEN_W-1:0]  nal_pos;
    logic [LEN_W-1:0]  unit_len_q;
    logic [MP_W-1:0]   frag_bytes;
    logic              in_fu;
    logic [4:0]        nal_type;

    task automatic emit_byte(input logic [7:0] value, input logic eop);
        rtp_bytes_due.push_back({value, eop, 1'b0});
    endtask

    task automatic emit_rtp_header();
        emit_byte(RTP_V2_BYTE, 1'b0);
        emit_byte({1'b0, pt_reg}, 1'b0);
        emit_byte(next_seq[15:8], 1'b0);
        emit_byte(next_seq[7:0], 1'b0);
        emit_byte(rtp_time[31:24], 1'b0);
        emit_byte(rtp_time[23:16], 1'b0);
        emit_byte(rtp_time[15:8], 1'b0);
        emit_byte(rtp_time[7:0], 1'b0);
        emit_byte(ssrc_reg[31:24], 1'b0);
        emit_byte(ssrc_reg[23:16], 1'b0);
        emit_byte(ssrc_reg[15:8], 1'b0);
        emit_byte(ssrc_reg[7:0], 1'b0);
    endtask

    task automatic close_unit();
        rtp_time   = rtp_time + TS_W'(ts_step_reg);
        nal_pos    = '0;
        frag_bytes = '0;
    endtask

    task automatic packetize_byte(input logic [7:0] b, input logic [LEN_W-1:0] len);
        int        lim;
        int        ulen;
        int        first;
        logic      done_body;
        logic      close_frag;
        logic [7:0] fu_hdr;
        t_rtp_byte tail;
        first = rtp_bytes_due.size();
        lim = (mp_reg < MP_MIN) ? int'(MP_MIN)
            : ((mp_reg > MP_MAX) ? int'(MP_MAX) : int'(mp_reg));
        if (nal_pos == 0) begin
            ulen       = (len == 0) ? 1 : int'(len);
            unit_len_q = LEN_W'(ulen);
            nal_type   = b[4:0];
            in_fu      = ulen > lim;
            frag_bytes = '0;
            if (in_fu) begin
                // NAL header byte is folded into the FU header; nothing goes out yet
                nal_pos = LEN_W'(1);
            end else begin
                emit_rtp_header();
                emit_byte(b, ulen == 1);
                if (ulen == 1) begin
                    next_seq = next_seq + 1'b1;
                    close_unit();
                end else begin
                    nal_pos = LEN_W'(1);
                end
            end
        end else if (!in_fu) begin
            done_body = int'(nal_pos) + 1 >= int'(unit_len_q);
            emit_byte(b, done_body);
            if (done_body) begin
                next_seq = next_seq + 1'b1;
                close_unit();
            end else begin
                nal_pos = nal_pos + 1'b1;
            end
        end else begin
            done_body  = int'(nal_pos) + 1 >= int'(unit_len_q);
            close_frag = done_body || (int'(frag_bytes) + 1 >= lim);
            if (frag_bytes == 0) begin
                fu_hdr = {3'b000, nal_type};
                if (nal_pos == 1) fu_hdr = fu_hdr | FU_START;
                // remaining body fits in this fragment
                if (int'(unit_len_q) - int'(nal_pos) <= lim) fu_hdr = fu_hdr | FU_END;
                emit_rtp_header();
                emit_byte(FU_INDICATOR, 1'b0);
                emit_byte(fu_hdr, 1'b0);
            end
            emit_byte(b, close_frag);
            if (close_frag) begin
                next_seq   = next_seq + 1'b1;
                frag_bytes = '0;
            end else begin
                frag_bytes = frag_bytes + 1'b1;
            end
            if (done_body) begin
                close_unit();
            end else begin
                nal_pos = nal_pos + 1'b1;
            end
        end
        if (rtp_bytes_due.size() > first) begin
            tail = rtp_bytes_due.pop_back();
            tail.last = 1'b1;
            rtp_bytes_due.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin
        t_rtp_byte due;
        if (!i_rst_n) begin
            pt_reg       = PT_RESET;
            ssrc_reg     = SSRC_RESET;
            ts_step_reg  = STEP_RESET;
            mp_reg       = MP_RESET;
            next_seq     = '0;
            rtp_time     = '0;
            nal_pos      = '0;
            unit_len_q   = '0;
            frag_bytes   = '0;
            in_fu        = 1'b0;
            nal_type     = '0;
            o_fail_count = 0;
            rtp_bytes_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PAYLOAD_TYPE: pt_reg      = i_cfg_data[PT_W-1:0];
                    CFG_SSRC:         ssrc_reg    = i_cfg_data[SSRC_W-1:0];
                    CFG_TS_STEP:      ts_step_reg = i_cfg_data[STEP_W-1:0];
                    CFG_MAX_PAYLOAD:  mp_reg      = i_cfg_data[MP_W-1:0];
                endcase
            end
            if (i_in_valid && !i_in_stall) packetize_byte(i_data_byte, i_nal_length);
            if (i_out_valid && !i_out_stall) begin
                if (rtp_bytes_due.size() == 0) begin
                    $display("%0t: unexpected output transaction: byte %02h eop %0b last %0b",
                             $time, i_out_byte, i_end_of_packet, i_last_of_run);
                    o_fail_count++;
                end else begin
                    due = rtp_bytes_due.pop_front();
                    if (i_out_byte !== due.value || i_end_of_packet !== due.eop
                        || i_last_of_run !== due.last) begin
                        $display({"%0t: mismatch: expected byte %02h eop %0b last %0b, ",
                                  "actual byte %02h eop %0b last %0b"},
                                 $time, due.value, due.eop, due.last,
                                 i_out_byte, i_end_of_packet, i_last_of_run);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = rtp_bytes_due.size();
    end

endmodule

// ----- bench/tb_h264_rtp_fua_packetizer.sv -----
`timescale 1ns / 1ps

module tb_h264_rtp_fua_packetizer;
    import h264rtp_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 12;
    localparam int RANDOM_PHASES  = 5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte;
    logic [LEN_W-1:0]      i_nal_length;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [7:0]            o_out_byte;
    logic                  o_end_of_packet;
    logic                  o_last_of_run;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic calm;
    logic hold_req;
    logic hold_done;

    h264_rtp_fua_packetizer dut (.*);

    h264_rtp_fua_packetizer_checker rtp_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_nal_length    (i_nal_length),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_byte      (o_out_byte),
        .i_end_of_packet (o_end_of_packet),
        .i_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // End the run when no transaction moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off to back up the block
    initial begin
        i_out_stall = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Entered and left at a falling edge; valid stays high into the next transaction
    task automatic send_byte(input logic [7:0] b, input logic [LEN_W-1:0] len);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_nal_length <= len;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Body bytes sometimes carry a stray length, which the block must ignore
    task automatic send_nal(input int ulen);
        logic [LEN_W-1:0] hdr_len;
        int k;
        hdr_len = (ulen == 1 && $urandom_range(0, 1) == 0) ? '0 : LEN_W'(ulen);
        send_byte(8'($urandom), hdr_len);
        for (k = 1; k < ulen; k++) begin
            send_byte(8'($urandom),
                      ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'(ulen));
        end
    endtask

    task automatic wait_for_packets();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        // cover a fragmented NAL header byte still in flight
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write registers from first_idx up to max_payload, valid held across writes
    task automatic load_config(input t_cfg_idx first_idx, input logic [PT_W-1:0] pt,
                               input logic [SSRC_W-1:0] ssrc, input logic [STEP_W-1:0] step,
                               input logic [MP_W-1:0] mp);
        logic [CFG_DATA_W-1:0] value;
        int k;
        for (k = int'(first_idx); k <= int'(CFG_MAX_PAYLOAD); k++) begin
            case (t_cfg_idx'(k))
                CFG_PAYLOAD_TYPE: value = CFG_DATA_W'(pt);
                CFG_SSRC:         value = ssrc;
                CFG_TS_STEP:      value = CFG_DATA_W'(step);
                default:          value = CFG_DATA_W'(mp);
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data  <= value;
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph;
        int sent;
        int ulen;
        int k;
        logic [MP_W-1:0] mp;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = '0;
        i_nal_length = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_PAYLOAD_TYPE;
        i_cfg_data   = '0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults: zero length as a one-byte NAL, then a whole packet with a stray length
        send_byte(8'h00, '0);
        send_byte(8'hFF, 16'd3);
        send_byte(8'h00, 16'd3);
        send_byte(8'hA5, 16'hFFFF);
        wait_for_packets();

        // Largest payload type and SSRC, smallest payload: two fragments, single S+E fragment, whole
        load_config(CFG_PAYLOAD_TYPE, 7'd127, 32'hFFFF_FFFF, 17'd90000, 13'd2);
        send_nal(4);
        send_nal(3);
        send_nal(2);
        wait_for_packets();

        // Bottom of every range; payload limit below the floor acts as two
        load_config(CFG_PAYLOAD_TYPE, '0, '0, '0, '0);
        send_nal(3);
        // Raise the limit past its ceiling halfway through a fragmented NAL
        for (k = 0; k < 6; k++) begin
            if (k == 3) begin
                wait_for_packets();
                load_config(CFG_MAX_PAYLOAD, '0, '0, '0, 13'h1FFF);
            end
            send_byte(8'($urandom), 16'd6);
        end
        wait_for_packets();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            calm = (ph == RANDOM_PHASES - 1);
            case (ph)
                0:       mp = MP_W'($urandom_range(2, 6));
                1:       mp = MP_W'($urandom_range(3, 12));
                2:       mp = MP_MAX;
                3:       mp = 13'd1;
                default: mp = MP_W'($urandom_range(2, 5));
            endcase
            load_config(CFG_PAYLOAD_TYPE, PT_W'($urandom), $urandom,
                        STEP_W'($urandom_range(0, 90000)), mp);
            hold_req = (ph == 1);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                ulen = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30)
                                                   : $urandom_range(1, 10);
                send_nal(ulen);
                sent += ulen;
            end
            wait_for_packets();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/h264rtp_pkg.sv
rtl/h264rtp_cfg.sv
rtl/h264rtp_parse.sv
rtl/h264rtp_emit.sv
rtl/h264_rtp_fua_packetizer.sv
rtl/h264rtp_check.sv
bench/h264_rtp_fua_packetizer_checker.sv
bench/tb_h264_rtp_fua_packetizer.sv
